[rtl/tcp_flow_feature_table_defines.svh]
// assertion macros for the flow feature table
`ifndef TCP_FLOW_FEATURE_TABLE_DEFINES_SVH
`define TCP_FLOW_FEATURE_TABLE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define TFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/tft_pkg.sv]
// shared types and constants of the flow feature table
`default_nettype none
package tft_pkg;
    localparam int FLOW_ENTRIES_DEF = 64;
    localparam int IN_W  = 136;
    localparam int OUT_W = 232;
    typedef struct packed {
        logic [47:0] time_ms;
        logic [15:0] seg_len;
        logic        ack_flag;
        logic        syn_flag;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
    } t_pkt;
    typedef struct packed {
        logic        table_full;
        logic [31:0] rev_bytes;
        logic [31:0] fwd_bytes;
        logic [31:0] rev_packets;
        logic [31:0] fwd_packets;
        logic [48:0] ackdat_delay;
        logic [48:0] synack_delay;
    } t_res;
    // one stored flow as held in the table ram
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] bytes;
        logic [31:0] pkts;
        logic [47:0] syn_t;
        logic [47:0] sa_t;
    } t_entry;
endpackage
`default_nettype wire

[rtl/tft_queue.sv]
// short queue between front and back
`default_nettype none
module tft_queue import tft_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_wvalid,
    output logic o_wready,
    input  t_pkt i_wdata,
    output logic o_rvalid,
    input  wire  i_rready,
    output t_pkt o_rdata
);
    t_pkt r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;
    assign o_wready = (r_cnt != 2'd2);
    assign o_rvalid = (r_cnt != 2'd0);
    assign o_rdata = r_q[r_rp];
    assign wr = i_wvalid && o_wready;
    assign rd = o_rvalid && i_rready;
    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
    // storage
    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= i_wdata;
    end
endmodule
`default_nettype wire

[rtl/tft_back.sv]
// generic table ram, then the flow scan, update and result stage
`default_nettype none
module tft_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  wire               i_clk,
    input  wire               i_we,
    input  wire  [ADDR_W-1:0] i_waddr,
    input  wire  [WIDTH-1:0]  i_wdata,
    input  wire  [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    assign o_rdata = r_rdata;
    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
endmodule

module tft_back import tft_pkg::*; #(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_pkt i_pkt,
    output logic o_valid,
    input  wire  i_ready,
    output t_res o_res
);
    localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = IW + 1;
    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_pkt r_pkt;
    logic [IW-1:0] r_addr, r_idx, r_fi;
    logic [CW-1:0] r_count;
    logic r_fhit, r_rhit, r_ov;
    t_entry r_fent;
    logic [31:0] r_rbytes, r_rpkts;
    t_res r_res;
    t_res n_res;
    logic [EW-1:0] ram_q;
    t_entry ent, went;
    logic [IW-1:0] waddr;
    logic take, last, fmatch, rmatch, same, room, emit, we;
    logic [32:0] bsum, psum;
    logic [31:0] nb, np;

    assign o_ready = (r_state == S_IDLE);
    assign take = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res = r_res;
    assign ent = t_entry'(ram_q);
    assign same = (r_pkt.src_ip == r_pkt.dst_ip);
    assign fmatch = (ent.key == {r_pkt.src_ip, r_pkt.dst_ip});
    assign rmatch = (ent.key == {r_pkt.dst_ip, r_pkt.src_ip});
    assign last = ({1'b0, r_idx} == r_count - CW'(1));
    assign room = (r_count < CW'(FLOW_ENTRIES));
    assign emit = (r_state == S_UPD) && (!r_ov || i_ready);

    // flows live in entries 0 to r_count-1, never removed
    tft_ram #(.WIDTH(EW), .DEPTH(FLOW_ENTRIES), .ADDR_W(IW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(went),
        .i_raddr(r_addr), .o_rdata(ram_q)
    );

    // control: accept, scan stored flows, update and emit
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (take) n_state = (r_count == '0) ? S_UPD : S_SCAN;
            S_SCAN: if (last) n_state = S_UPD;
            S_UPD:  if (emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // flow update and feature word
    always_comb begin
        bsum = {1'b0, r_fent.bytes} + {17'd0, r_pkt.seg_len};
        psum = {1'b0, r_fent.pkts} + 33'd1;
        nb = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
        np = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
        n_res = '0;
        went = r_fent;
        waddr = r_fi;
        we = 1'b0;
        if (r_fhit) begin
            went.bytes = nb;
            went.pkts = np;
            if (r_pkt.syn_flag) went.syn_t = r_pkt.time_ms;
            if (r_pkt.syn_flag && r_pkt.ack_flag) begin
                went.sa_t = r_pkt.time_ms;
                n_res.synack_delay = {1'b0, r_pkt.time_ms} - {1'b0, r_fent.syn_t};
            end
            if (r_pkt.ack_flag)
                n_res.ackdat_delay = {1'b0, r_pkt.time_ms} - {1'b0, r_fent.sa_t};
            we = emit;
        end else if (room) begin
            went.key = {r_pkt.src_ip, r_pkt.dst_ip};
            went.bytes = {16'd0, r_pkt.seg_len};
            went.pkts = 32'd1;
            went.syn_t = r_pkt.syn_flag ? r_pkt.time_ms : 48'd0;
            went.sa_t = (r_pkt.syn_flag && r_pkt.ack_flag) ? r_pkt.time_ms : 48'd0;
            waddr = r_count[IW-1:0];
            we = emit;
        end else begin
            n_res.table_full = 1'b1;
        end
        if (!n_res.table_full) begin
            n_res.fwd_packets = went.pkts;
            n_res.fwd_bytes = went.bytes;
        end
        // equal addresses: the reverse flow is the forward flow
        if (same) begin
            n_res.rev_packets = n_res.fwd_packets;
            n_res.rev_bytes = n_res.fwd_bytes;
        end else if (r_rhit) begin
            n_res.rev_packets = r_rpkts;
            n_res.rev_bytes = r_rbytes;
        end
    end

    // state, read address, fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr <= '0;
            r_count <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (take) r_addr <= IW'(1);
                S_SCAN: r_addr <= last ? '0 : r_addr + IW'(1);
                S_UPD: r_addr <= '0;
                default: r_addr <= '0;
            endcase
            if (emit && !r_fhit && room) r_count <= r_count + CW'(1);
            if (emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    // packet, scan hits and result
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pkt <= i_pkt;
            r_idx <= '0;
            r_fhit <= 1'b0;
            r_rhit <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + IW'(1);
            if (fmatch) begin
                r_fhit <= 1'b1;
                r_fi <= r_idx;
                r_fent <= ent;
            end
            if (rmatch) begin
                r_rhit <= 1'b1;
                r_rbytes <= ent.bytes;
                r_rpkts <= ent.pkts;
            end
        end
        if (emit) r_res <= n_res;
    end
endmodule
`default_nettype wire

[rtl/tcp_flow_feature_table.sv]
// Flow feature table: one packet word in, one feature word out. Incoming
// descriptors wait in a two-word queue; the back end reads the stored flows
// from a table RAM one entry per cycle, matching the forward and the reverse
// address pair together, then updates or allocates the flow and registers
// the result. With N flows stored a packet holds the back end while it scans
// the N entries and then updates the flow; the back end takes no new packet
// until its result is registered, and a stalled output holds it in the update
// state. Flows are never removed: once FLOW_ENTRIES flows are stored a new
// flow is dropped and reported with table_full.
`default_nettype none
module tcp_flow_feature_table import tft_pkg::*; #(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    // src_ip, dst_ip, syn_flag, ack_flag, seg_len, time_ms, zero fill
    input  wire [IN_W-1:0]   s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    // synack_delay, ackdat_delay, fwd_packets, rev_packets, fwd_bytes,
    // rev_bytes, table_full, zero fill
    output logic [OUT_W-1:0] m_axis_tdata
);
    t_pkt qd;
    logic qv, qr;
    t_res res;
    tft_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wvalid(s_axis_tvalid), .o_wready(s_axis_tready),
        .i_wdata(s_axis_tdata[$bits(t_pkt)-1:0]),
        .o_rvalid(qv), .i_rready(qr), .o_rdata(qd)
    );
    tft_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(qv), .o_ready(qr), .i_pkt(qd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );
    assign m_axis_tdata = {5'd0, res};
endmodule
`default_nettype wire

[rtl/tft_checker.sv]
// port-level checks of the flow feature table
`default_nettype none
`include "tcp_flow_feature_table_defines.svh"
module tft_checker import tft_pkg::*; (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             m_axis_tvalid,
    input wire             m_axis_tready,
    input wire [OUT_W-1:0] m_axis_tdata
);
    `TFT_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TFT_ASSERT_NXT(a_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata))
    `TFT_ASSERT_IMP(a_full_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[226],
        m_axis_tdata[129:98] == 32'd0)
    `TFT_ASSERT_IMP(a_fwd_nz, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[226],
        m_axis_tdata[129:98] != 32'd0)
    `TFT_ASSERT_IMP(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[231:227] == 5'd0)
endmodule
bind tcp_flow_feature_table tft_checker u_chk (.*);
`default_nettype wire
